@@ src/binary_min_heap_queue_macros.svh @@
// Assertion macros used by the verification file of the heap queue.
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BMHQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BMHQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

@@ src/bmhq_pkg.sv @@
// Package with the types, constants and compare function of the heap queue.
package bmhq_pkg;

    // Fixed field widths and the default capacity.
    localparam int KEY_WIDTH    = 32;
    localparam int SRC_WIDTH    = 4;
    localparam int HELD_WIDTH   = 5;
    localparam int DEF_CAPACITY = 16;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // One stored heap entry.
    typedef struct packed {
        logic [SRC_WIDTH-1:0] source;
        logic [KEY_WIDTH-1:0] key;
    } heap_entry_t;

    // Input request payload.
    typedef struct packed {
        logic                 operation;
        logic [SRC_WIDTH-1:0] source_id;
        logic [KEY_WIDTH-1:0] sort_key;
    } request_t;

    // Result payload.
    typedef struct packed {
        logic [SRC_WIDTH-1:0]  head_source;
        logic [KEY_WIDTH-1:0]  head_key;
        logic                  popped;
        logic                  fault;
        logic [HELD_WIDTH-1:0] entries_held;
        logic                  is_empty;
    } result_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CHECK,
        ST_UP_CMP,
        ST_POP_LOAD,
        ST_DN_CHECK,
        ST_DN_CMP
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic init_up;
        logic rd_up;
        logic move_up;
        logic rd_pop;
        logic load_pop;
        logic rd_down;
        logic move_down;
        logic place;
        logic finish;
        logic fault;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_pop;
        logic full;
        logic empty;
        logic at_root;
        logic up_swap;
        logic leaf;
        logic dn_swap;
    } dp_status_t;

    // True when key a must be served after key b in the current order.
    function automatic logic serves_after(input logic rev,
                                          input logic [KEY_WIDTH-1:0] a,
                                          input logic [KEY_WIDTH-1:0] b);
        logic res;
        res = rev ? (a < b) : (a > b);
        return res;
    endfunction

endpackage

@@ src/bmhq_ctrl.sv @@
// Controller state machine that sequences heap inserts and pops.
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output logic       busy,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (status.req_pop)
                    begin
                        if (status.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.fault  = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_pop = 1'b1;
                            state_next = ST_POP_LOAD;
                        end
                    end
                    else
                    begin
                        if (status.full)
                        begin
                            cmd.finish = 1'b1;
                            cmd.fault  = 1'b1;
                        end
                        else
                        begin
                            cmd.init_up = 1'b1;
                            state_next  = ST_UP_CHECK;
                        end
                    end
                end
            end
            ST_UP_CHECK:
            begin
                if (status.at_root)
                begin
                    cmd.place  = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_up  = 1'b1;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (status.up_swap)
                begin
                    cmd.move_up = 1'b1;
                    state_next  = ST_UP_CHECK;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_POP_LOAD:
            begin
                cmd.load_pop = 1'b1;
                state_next   = ST_DN_CHECK;
            end
            ST_DN_CHECK:
            begin
                if (status.leaf)
                begin
                    cmd.place  = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_down = 1'b1;
                    state_next  = ST_DN_CMP;
                end
            end
            ST_DN_CMP:
            begin
                if (status.dn_swap)
                begin
                    cmd.move_down = 1'b1;
                    state_next    = ST_DN_CHECK;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ src/bmhq_datapath.sv @@
// Datapath of the heap queue: entry memory, sift registers and result register.
module bmhq_datapath
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_data,
    input  request_t   request,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output result_t    result,
    output logic       result_valid
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = PW + 1;

    // Entry memory, positions 1..CAPACITY stored at addresses 0..CAPACITY-1.
    heap_entry_t heap_mem [CAPACITY];

    logic              reverse_reg;
    logic [PW-1:0]     count_reg;
    logic [PW-1:0]     count_next;
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    heap_entry_t       moving_reg;
    heap_entry_t       moving_next;
    heap_entry_t       head_reg;
    heap_entry_t       head_next;
    logic              op_reg;
    logic              op_next;
    heap_entry_t       rd_a_reg;
    heap_entry_t       rd_b_reg;
    result_t           result_reg;
    result_t           result_next;
    logic              result_valid_reg;

    logic [AW-1:0]     rd_a_addr;
    logic [AW-1:0]     rd_b_addr;
    logic [AW-1:0]     wr_addr;
    heap_entry_t       wr_data;
    logic              wr_en;

    logic [LW-1:0]     left_pos;
    logic [LW-1:0]     count_ext;
    logic              right_exists;
    logic              take_right;
    heap_entry_t       child;
    logic [PW-1:0]     child_pos;

    // Child selection for the downward sift.
    assign left_pos     = {pos_reg, 1'b0};
    assign count_ext    = {1'b0, count_reg};
    assign right_exists = (left_pos < count_ext);
    assign take_right   = right_exists && serves_after(reverse_reg, rd_a_reg.key, rd_b_reg.key);
    assign child        = take_right ? rd_b_reg : rd_a_reg;
    assign child_pos    = take_right ? PW'(left_pos + LW'(1)) : PW'(left_pos);

    // Status toward the controller.
    always_comb
    begin
        status.req_pop = (request.operation == OP_POP);
        status.full    = (count_reg == PW'(CAPACITY));
        status.empty   = (count_reg == '0);
        status.at_root = (pos_reg == PW'(1));
        status.up_swap = serves_after(reverse_reg, rd_a_reg.key, moving_reg.key);
        status.leaf    = (left_pos > count_ext);
        status.dn_swap = serves_after(reverse_reg, moving_reg.key, child.key);
    end

    // Memory addresses and write data.
    always_comb
    begin
        rd_a_addr = '0;
        rd_b_addr = '0;
        if (cmd.rd_up)
        begin
            rd_a_addr = AW'((pos_reg >> 1) - PW'(1));
        end
        if (cmd.rd_pop)
        begin
            rd_b_addr = AW'(count_reg - PW'(1));
        end
        if (cmd.rd_down)
        begin
            rd_a_addr = AW'(left_pos - LW'(1));
            rd_b_addr = AW'(left_pos);
        end
        wr_addr = AW'(pos_reg - PW'(1));
        wr_en   = cmd.place | cmd.move_up | cmd.move_down;
        wr_data = moving_reg;
        if (cmd.move_up)
        begin
            wr_data = rd_a_reg;
        end
        if (cmd.move_down)
        begin
            wr_data = child;
        end
    end

    // Entry memory with registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_a_addr];
        rd_b_reg <= heap_mem[rd_b_addr];
    end

    // Next values of the sift registers.
    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        moving_next = moving_reg;
        head_next   = head_reg;
        op_next     = op_reg;
        if (cmd.accept)
        begin
            op_next = request.operation;
        end
        if (cmd.init_up)
        begin
            count_next         = count_reg + PW'(1);
            pos_next           = count_reg + PW'(1);
            moving_next.source = request.source_id;
            moving_next.key    = request.sort_key;
        end
        if (cmd.load_pop)
        begin
            count_next  = count_reg - PW'(1);
            pos_next    = PW'(1);
            moving_next = rd_b_reg;
            head_next   = rd_a_reg;
        end
        if (cmd.move_up)
        begin
            pos_next = pos_reg >> 1;
        end
        if (cmd.move_down)
        begin
            pos_next = child_pos;
        end
    end

    // Result formed on the last cycle of a request.
    always_comb
    begin
        result_next              = '0;
        result_next.fault        = cmd.fault;
        result_next.popped       = !cmd.fault && (op_reg == OP_POP);
        result_next.entries_held = HELD_WIDTH'(count_reg);
        result_next.is_empty     = (count_reg == '0);
        if (result_next.popped)
        begin
            result_next.head_source = head_reg.source;
            result_next.head_key    = head_reg.key;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg      <= 1'b0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                reverse_reg <= cfg_data;
            end
            count_reg        <= count_next;
            result_valid_reg <= cmd.finish;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        moving_reg <= moving_next;
        head_reg   <= head_next;
        op_reg     <= op_next;
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

@@ src/binary_min_heap_queue.sv @@
// Top level of the binary heap priority queue for a k-way merge selector.
//
//   Channel   Handshake                 Payload
//   --------  ------------------------  ------------------------------
//   request   start, busy               request  (request_t)
//   result    result_valid (strobe)     result   (result_t)
//   config    cfg_write                 cfg_data (reverse order flag)
//
// A request is taken when start is high and busy is low; one request is
// worked at a time. An insert climbs until it reaches the root or a compare
// stops it; a pop moves the last entry to the root and descends until it
// reaches a leaf or a compare stops it. A faulted request (a pop when empty
// or an insert when full) is answered without leaving idle. The result strobe
// comes in the first idle cycle and cannot be stalled. Reset clears the count,
// the order flag, the result strobe and the controller state.
module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_write,
    input  logic     cfg_data,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     result_valid,
    output result_t  result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencing.
    bmhq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Storage and compare.
    bmhq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .request      (request),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

@@ src/bmhq_checker.sv @@
// Port-level checker for the heap queue and its bind to the top level.
`include "binary_min_heap_queue_macros.svh"

module bmhq_checker
    import bmhq_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     result_valid,
    input result_t  result
);

    // A result never both carries an entry and reports a fault.
    `BMHQ_ASSERT_IMP(a_pop_xor_fault, clk, rst_n, result_valid, !(result.popped && result.fault))

    // A result without a popped entry shows zero head fields.
    `BMHQ_ASSERT_IMP(a_head_zero, clk, rst_n, result_valid && !result.popped, (result.head_key == '0) && (result.head_source == '0))

    // An accepted request either keeps the block busy or answers at once.
    `BMHQ_ASSERT_NXT(a_accept_progress, clk, rst_n, start && !busy, busy || result_valid)

    // A result only follows work in progress or a request taken.
    `BMHQ_ASSERT_IMP(a_result_cause, clk, rst_n, result_valid, $past(busy) || $past(start))

endmodule

bind binary_min_heap_queue bmhq_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
